### hw/rtl/mssm_pkg.sv
// Package for the shared-memory multi-stack unit.
// Holds default sizes, field widths, opcodes, status codes and the slot command type.
// No dependencies.
package mssm_pkg;

  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_CAPACITY   = 64;

  localparam int DATA_W   = 32;
  localparam int SN_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef struct packed {
    logic rd;
    logic wr_data;
    logic wr_link;
  } slot_cmd_t;

endpackage

### hw/rtl/mssm_slots.sv
// Slot store of the multi-stack unit: data and link memories with registered reads.
// Links of slots at or above the fill mark read as the next slot index.
// Depends on mssm_pkg.
module mssm_slots import mssm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_cmd_t         cmd_i,
  input  logic [LW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [LW-1:0]     wlink_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic [LW-1:0]     rlink_o
);

  localparam int AW = $clog2(CAPACITY);

  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [LW-1:0]     link_mem [CAPACITY];

  logic [DATA_W-1:0] data_q;
  logic [LW-1:0]     link_q;
  logic [LW-1:0]     rd_addr_q;
  logic              fresh_q;
  logic [LW-1:0]     wm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data) begin
      data_mem[addr_i[AW-1:0]] <= wdata_i;
    end
    if (cmd_i.wr_link) begin
      link_mem[addr_i[AW-1:0]] <= wlink_i;
    end
    if (cmd_i.rd) begin
      data_q    <= data_mem[addr_i[AW-1:0]];
      link_q    <= link_mem[addr_i[AW-1:0]];
      rd_addr_q <= addr_i;
      fresh_q   <= (addr_i >= wm_q);
    end
  end

  // advance the fill mark when the first untouched slot gets linked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm_q <= '0;
    end else if (cmd_i.wr_link && addr_i == wm_q) begin
      wm_q <= wm_q + LW'(1);
    end
  end

  assign rdata_o = data_q;
  assign rlink_o = fresh_q ? rd_addr_q + LW'(1) : link_q;

endmodule

### hw/rtl/multi_stack_shared_memory_unit.sv
// Top level of the shared-memory multi-stack unit: sequencer, stack heads, free list head.
// Instantiates mssm_slots; depends on mssm_pkg.
//
// NUM_STACKS LIFO stacks share CAPACITY slots; unused slots sit on a free list.
// One item is handled at a time. After acceptance the item passes through the head lookup
// state and the slot link state to the result state (it skips the link state when a push
// overflows or a pop finds its stack empty). The result waits in the result state under
// out_stall_i, and the next item is taken in the cycle after the result leaves. The steps
// are set by two dependent synchronous memory reads: the stack head table first, then the
// slot link and data. The write-back comes after them, and then the result handshake. No
// clearing pass runs after reset; the unit takes items in the first cycle after reset.
module multi_stack_shared_memory_unit import mssm_pkg::*; #(
  parameter int NUM_STACKS = DEF_NUM_STACKS,
  parameter int CAPACITY   = DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [SN_W-1:0]     stack_num_i,
  input  logic [DATA_W-1:0]   push_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DATA_W-1:0]   pop_value_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int NSW  = $clog2(NUM_STACKS + 1);
  localparam int SNX  = (NSW > SN_W) ? NSW : SN_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              op_q;
  logic [SW-1:0]     sn_q;
  logic              sn_ok_q;
  logic [DATA_W-1:0] val_q;
  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     head_q, head_d;
  logic [LW-1:0]     free_q, free_d;
  logic [DATA_W-1:0] pop_q, pop_d;
  status_e           status_q, status_d;

  logic [LW-1:0]     head_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] head_vld_q;
  logic [LW-1:0]     head_rd_q;
  logic              head_rd_vld_q;

  logic              accept;
  logic [SNX-1:0]    sn_ext;
  logic [LW-1:0]     head_cur;
  logic              head_wr;
  logic [LW-1:0]     head_wdata;
  slot_cmd_t         slot_cmd;
  logic [LW-1:0]     slot_addr;
  logic [DATA_W-1:0] slot_rdata;
  logic [LW-1:0]     slot_rlink;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign sn_ext     = SNX'(stack_num_i);
  assign head_cur   = head_rd_vld_q ? head_rd_q : NULL_LINK;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    head_d     = head_q;
    free_d     = free_q;
    pop_d      = pop_q;
    status_d   = status_q;
    slot_cmd   = '0;
    slot_addr  = idx_q;
    head_wr    = 1'b0;
    head_wdata = slot_rlink;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        head_d = head_cur;
        pop_d  = '0;
        if (op_q == OP_PUSH) begin
          idx_d = free_q;
          if (!sn_ok_q || free_q == NULL_LINK) begin
            status_d = STATUS_OVERFLOW;
            state_d  = S_OUT;
          end else begin
            status_d = STATUS_OK;
            state_d  = S_LINK;
          end
        end else begin
          idx_d = head_cur;
          if (!sn_ok_q || head_cur == NULL_LINK) begin
            status_d = STATUS_EMPTY;
            state_d  = S_OUT;
          end else begin
            status_d = STATUS_OK;
            state_d  = S_LINK;
          end
        end
        slot_addr   = idx_d;
        slot_cmd.rd = (state_d == S_LINK);
      end
      S_LINK: begin
        slot_cmd.wr_link = 1'b1;
        head_wr          = 1'b1;
        if (op_q == OP_PUSH) begin
          slot_cmd.wr_data = 1'b1;
          head_wdata       = idx_q;
          free_d           = slot_rlink;
        end else begin
          head_wdata = slot_rlink;
          free_d     = idx_q;
          pop_d      = slot_rdata;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_q     <= '0;
      head_vld_q <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (head_wr) begin
        head_vld_q[sn_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q          <= op_i;
      sn_q          <= sn_ext[SW-1:0];
      sn_ok_q       <= (sn_ext < SNX'(NUM_STACKS));
      val_q         <= push_value_i;
      head_rd_q     <= head_mem[sn_ext[SW-1:0]];
      head_rd_vld_q <= head_vld_q[sn_ext[SW-1:0]];
    end
    if (head_wr) begin
      head_mem[sn_q] <= head_wdata;
    end
    idx_q    <= idx_d;
    head_q   <= head_d;
    pop_q    <= pop_d;
    status_q <= status_d;
  end

  mssm_slots #(
    .CAPACITY (CAPACITY),
    .LW       (LW)
  ) u_slots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (slot_cmd),
    .addr_i  (slot_addr),
    .wdata_i (val_q),
    .wlink_i ((op_q == OP_PUSH) ? head_q : free_q),
    .rdata_o (slot_rdata),
    .rlink_o (slot_rlink)
  );

  assign out_valid_o = (state_q == S_OUT);
  assign pop_value_o = pop_q;
  assign status_o    = status_q;

  a_accept_to_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_HEAD))
    else $error("accepted item did not start head lookup");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> (pop_value_o == '0))
    else $error("rejected item carries nonzero pop value");

  a_push_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op_q == OP_PUSH) |-> (pop_value_o == '0 && status_o != STATUS_EMPTY))
    else $error("push result malformed");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

endmodule

### dv/multi_stack_checker.sv
// Checker for multi_stack_shared_memory_unit: watches both item channels, keeps its own
// copy of the stacks and the free list, predicts each result and compares it field by field.
// Depends on mssm_pkg.
module multi_stack_checker import mssm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                op_i,
  input  logic [SN_W-1:0]     stack_num_i,
  input  logic [DATA_W-1:0]   push_value_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [DATA_W-1:0]   pop_value_i,
  input  logic [STATUS_W-1:0] status_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  overflows_o,
  output int                  empties_o
);

  localparam int STACKS = DEF_NUM_STACKS;
  localparam int SLOTS  = DEF_CAPACITY;
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_e           status;
  } stack_reply_t;

  logic [DATA_W-1:0] slot_word [SLOTS];
  logic [LINK_W-1:0] slot_next [SLOTS];
  logic [LINK_W-1:0] top_slot  [STACKS];
  logic [LINK_W-1:0] free_slot;

  stack_reply_t replies [$];
  stack_reply_t want;
  int fails;
  int results;
  int overflows;
  int empties;

  function automatic stack_reply_t apply_stack_op(input logic op, input logic [SN_W-1:0] sn,
                                                  input logic [DATA_W-1:0] value);
    stack_reply_t r;
    logic [LINK_W-1:0] slot;
    r.pop_value = '0;
    if (op == OP_PUSH) begin
      slot = free_slot;
      if (sn >= STACKS || slot >= SLOTS) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        free_slot       = slot_next[slot];
        slot_word[slot] = value;
        slot_next[slot] = top_slot[sn];
        top_slot[sn]    = slot;
        r.status        = STATUS_OK;
      end
    end else begin
      slot = (sn < STACKS) ? top_slot[sn] : NULL_LINK;
      if (slot >= SLOTS) begin
        r.status = STATUS_EMPTY;
      end else begin
        top_slot[sn]    = slot_next[slot];
        slot_next[slot] = free_slot;
        free_slot       = slot;
        r.pop_value     = slot_word[slot];
        r.status        = STATUS_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_word[k] = '0;
        slot_next[k] = LINK_W'(k + 1);
      end
      for (int k = 0; k < STACKS; k++) begin
        top_slot[k] = NULL_LINK;
      end
      free_slot = '0;
      replies.delete();
      fails     = 0;
      results   = 0;
      overflows = 0;
      empties   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      overflows_o  <= 0;
      empties_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies.size() == 0) begin
          $error("result item with no item outstanding: pop_value %h status %0d",
                 pop_value_i, status_i);
          fails++;
        end else begin
          want = replies.pop_front();
          results++;
          if (want.status == STATUS_OVERFLOW) overflows++;
          if (want.status == STATUS_EMPTY) empties++;
          if (pop_value_i !== want.pop_value) begin
            $error("pop_value mismatch: expected %h, actual %h", want.pop_value, pop_value_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        replies.push_back(apply_stack_op(op_i, stack_num_i, push_value_i));
      end
      fail_count_o <= fails;
      pending_o    <= replies.size();
      results_o    <= results;
      overflows_o  <= overflows;
      empties_o    <= empties;
    end
  end

endmodule

### dv/tb_multi_stack_shared_memory_unit.sv
// Testbench top for multi_stack_shared_memory_unit: clock, reset, item stimulus and verdict.
// Depends on mssm_pkg, the unit and multi_stack_checker.
module tb_multi_stack_shared_memory_unit;
  import mssm_pkg::*;

  localparam int RANDOM_PER_PHASE = 435;
  localparam int LONG_HOLD        = 60;
  localparam int CYCLE_LIMIT      = 300000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic                in_op     = OP_PUSH;
  logic [SN_W-1:0]     in_sn     = '0;
  logic [DATA_W-1:0]   in_value  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   pop_value;
  logic [STATUS_W-1:0] status;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int fail_count;
  int pending;
  int results;
  int overflows;
  int empties;

  always #5 clk = ~clk;

  multi_stack_shared_memory_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (in_op),
    .stack_num_i  (in_sn),
    .push_value_i (in_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pop_value_o  (pop_value),
    .status_o     (status)
  );

  multi_stack_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (in_op),
    .stack_num_i  (in_sn),
    .push_value_i (in_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pop_value_i  (pop_value),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .overflows_o  (overflows),
    .empties_o    (empties)
  );

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [SN_W-1:0] sn,
                           input logic [DATA_W-1:0] value);
    in_valid <= 1'b1;
    in_op    <= op;
    in_sn    <= sn;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int push_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // pop empty stacks, push extreme words, pop them back in LIFO order
    send_item(OP_POP, 2'd0, '0);
    send_item(OP_POP, 2'd1, '1);
    send_item(OP_POP, 2'd2, '0);
    send_item(OP_POP, 2'd3, '1);
    send_item(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 2'd1, 32'h8000_0000);
    send_item(OP_PUSH, 2'd2, 32'h0000_0000);
    send_item(OP_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 2'd0, 32'h5555_5555);
    send_item(OP_PUSH, 2'd0, 32'hAAAA_AAAA);
    send_item(OP_POP, 2'd0, '0);
    send_item(OP_POP, 2'd0, '0);
    send_item(OP_POP, 2'd0, '0);
    send_item(OP_POP, 2'd0, '0);
    send_item(OP_POP, 2'd3, '0);
    send_item(OP_POP, 2'd2, '0);
    send_item(OP_POP, 2'd1, '0);
    send_item(OP_POP, 2'd1, '0);
    wait_for_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 49;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct <= 14;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 0 && n == RANDOM_PER_PHASE / 2) hold_requests <= hold_requests + 1;
        // fill to overflow, drain to empty, then mixed runs
        case ((n / 70) % 6)
          0: push_pct = 100;
          1: push_pct = 0;
          2: push_pct = 80;
          3: push_pct = 20;
          4: push_pct = 50;
          default: push_pct = 90;
        endcase
        send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
                  SN_W'($urandom_range(3)), $urandom());
      end
      wait_for_drain();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d items, checked %0d results (%0d overflows, %0d empty pops)",
             items_sent, results, overflows, empties);
    $display("idling mixes: none, sender, receiver, both; one long output hold");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
